@@ hw/rtl/grc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and tables of the grid ray-cast column core
package grc_pkg;

	localparam int SCREEN_WIDTH  = 120;
	localparam int SCREEN_HEIGHT = 40;
	localparam int MAP_SIZE      = 16;

	localparam int DIST_W  = 17;
	localparam int ROW_W   = 6;
	localparam int GLYPH_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DEPTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOV        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd2;

	localparam logic [16:0] VIEW_DEPTH_RST = 17'd65536;
	localparam logic [11:0] FOV_RST        = 12'd512;
	localparam logic [12:0] STEP_RST       = 13'd410;

	// opcodes
	localparam logic OP_MAP_WRITE = 1'b0;
	localparam logic OP_CAST      = 1'b1;

	// glyph codes
	localparam logic [GLYPH_W-1:0] GL_BLANK  = 4'd0;
	localparam logic [GLYPH_W-1:0] GL_FULL   = 4'd1;
	localparam logic [GLYPH_W-1:0] GL_DARK   = 4'd2;
	localparam logic [GLYPH_W-1:0] GL_MEDIUM = 4'd3;
	localparam logic [GLYPH_W-1:0] GL_LIGHT  = 4'd4;
	localparam logic [GLYPH_W-1:0] GL_HASH   = 4'd5;
	localparam logic [GLYPH_W-1:0] GL_X      = 4'd6;
	localparam logic [GLYPH_W-1:0] GL_DOT    = 4'd7;
	localparam logic [GLYPH_W-1:0] GL_DASH   = 4'd8;

	localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

	// column * fov / SCREEN_WIDTH by reciprocal multiply
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

	// sine polynomial coefficients, Q.14
	localparam logic [14:0] POLY_C0 = 15'd77;
	localparam logic [14:0] POLY_C1 = 15'd1306;
	localparam logic [14:0] POLY_C2 = 15'd10584;
	localparam logic [14:0] POLY_C3 = 15'd25736;
	localparam int TRIG_PHASES = 5;

	// projected height numerator H * 2^24
	localparam int DIV_W = 30;
	localparam logic [DIV_W-1:0] DIV_NUM = DIV_W'(SCREEN_HEIGHT) << 24;

	localparam int EDGE_CYCLES = 8;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  map_row;
		logic [15:0] row_walls;
		logic [6:0]  column;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [11:0] heading;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0]   screen_row;
		logic [GLYPH_W-1:0] glyph;
		logic [DIST_W-1:0]  wall_distance;
		logic               tile_edge;
		logic               last_row;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANG1,
		ST_ANG2,
		ST_TRIG,
		ST_SETUP,
		ST_MFIRST,
		ST_MARCH,
		ST_EDGE,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             map_wr;
		logic             ang1;
		logic             ang2;
		logic             trig;
		logic [2:0]       phase;
		logic             setup;
		logic             mfirst;
		logic             march;
		logic             edge_feed;
		logic [1:0]       edge_idx;
		logic             div_init;
		logic             div_step;
		logic             fin;
		logic             emit;
		logic [ROW_W-1:0] row;
	} cmd_t;

	typedef struct packed {
		logic depth_zero;
		logic m_end;
		logic m_wall;
		logic out_free;
	} sts_t;

	// floor shade by screen row
	function automatic logic [GLYPH_W-1:0] floor_glyph(input logic [ROW_W-1:0] i);
		int r;
		logic [GLYPH_W-1:0] g;
		r = SCREEN_HEIGHT - int'(i);
		if (8 * r < SCREEN_HEIGHT) g = GL_HASH;
		else if (4 * r < SCREEN_HEIGHT) g = GL_X;
		else if (8 * r < 3 * SCREEN_HEIGHT) g = GL_DOT;
		else if (20 * r < 9 * SCREEN_HEIGHT) g = GL_DASH;
		else g = GL_BLANK;
		return g;
	endfunction

endpackage

@@ hw/rtl/grc_stream_if.sv @@
`timescale 1ns / 1ps
// valid/ready stream channel with a typed payload
interface grc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ hw/rtl/grc_ctrl.sv @@
`timescale 1ns / 1ps
// sequencing state machine of the ray-cast column core
module grc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_opcode,
	output logic              req_ready,
	input  grc_pkg::sts_t     sts,
	output grc_pkg::cmd_t     cmd
);

	grc_pkg::state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			grc_pkg::ST_IDLE: begin
				if (req_valid && req_opcode == grc_pkg::OP_CAST) begin
					state_d = grc_pkg::ST_ANG1;
				end
			end
			grc_pkg::ST_ANG1: state_d = grc_pkg::ST_ANG2;
			grc_pkg::ST_ANG2: begin
				state_d = grc_pkg::ST_TRIG;
				cnt_d   = '0;
			end
			grc_pkg::ST_TRIG: begin
				if (cnt_q == 6'(grc_pkg::TRIG_PHASES - 1)) begin
					state_d = grc_pkg::ST_SETUP;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			grc_pkg::ST_SETUP: state_d = grc_pkg::ST_MFIRST;
			grc_pkg::ST_MFIRST: begin
				cnt_d   = '0;
				state_d = sts.depth_zero ? grc_pkg::ST_DIV : grc_pkg::ST_MARCH;
			end
			grc_pkg::ST_MARCH: begin
				cnt_d = '0;
				if (sts.m_end) begin
					state_d = sts.m_wall ? grc_pkg::ST_EDGE : grc_pkg::ST_DIV;
				end
			end
			grc_pkg::ST_EDGE: begin
				if (cnt_q == 6'(grc_pkg::EDGE_CYCLES - 1)) begin
					state_d = grc_pkg::ST_DIV;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			grc_pkg::ST_DIV: begin
				if (cnt_q == 6'(grc_pkg::DIV_W)) begin
					state_d = grc_pkg::ST_FIN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			grc_pkg::ST_FIN: begin
				state_d = grc_pkg::ST_EMIT;
				cnt_d   = '0;
			end
			grc_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					if (cnt_q == 6'(grc_pkg::SCREEN_HEIGHT - 1)) begin
						state_d = grc_pkg::ST_IDLE;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + 6'd1;
					end
				end
			end
			default: begin
				state_d = grc_pkg::ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		cmd.phase = cnt_q[2:0];
		cmd.edge_idx = cnt_q[1:0];
		cmd.row   = cnt_q;
		case (state_q)
			grc_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.load   = req_valid;
				cmd.map_wr = req_valid && req_opcode == grc_pkg::OP_MAP_WRITE;
			end
			grc_pkg::ST_ANG1:   cmd.ang1 = 1'b1;
			grc_pkg::ST_ANG2:   cmd.ang2 = 1'b1;
			grc_pkg::ST_TRIG:   cmd.trig = 1'b1;
			grc_pkg::ST_SETUP:  cmd.setup = 1'b1;
			grc_pkg::ST_MFIRST: cmd.mfirst = !sts.depth_zero;
			grc_pkg::ST_MARCH:  cmd.march = 1'b1;
			grc_pkg::ST_EDGE:   cmd.edge_feed = (cnt_q < 6'd4);
			grc_pkg::ST_DIV: begin
				cmd.div_init = (cnt_q == 6'd0);
				cmd.div_step = (cnt_q != 6'd0);
			end
			grc_pkg::ST_FIN:    cmd.fin = 1'b1;
			grc_pkg::ST_EMIT:   cmd.emit = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/grc_dp.sv @@
`timescale 1ns / 1ps
// datapath of the ray-cast column core: map, trig, march, corner test, divider, shading
module grc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  grc_pkg::cmd_t                       cmd,
	output grc_pkg::sts_t                       sts,
	input  logic                                cfg_we,
	input  logic [grc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [grc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  grc_pkg::req_t                       req_data,
	input  logic                                rsp_ready,
	output logic                                rsp_valid,
	output grc_pkg::rsp_t                       rsp_data
);

	// configuration
	logic [16:0] depth_q;
	logic [11:0] fov_q;
	logic [12:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= grc_pkg::VIEW_DEPTH_RST;
			fov_q   <= grc_pkg::FOV_RST;
			step_q  <= grc_pkg::STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				grc_pkg::CFG_VIEW_DEPTH: depth_q <= cfg_data;
				grc_pkg::CFG_FOV:        fov_q   <= cfg_data[11:0];
				grc_pkg::CFG_STEP:       step_q  <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// wall map
	logic [15:0] map_q [grc_pkg::MAP_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < grc_pkg::MAP_SIZE; r++) map_q[r] <= '0;
		end else if (cmd.map_wr && int'(req_data.map_row) < grc_pkg::MAP_SIZE) begin
			map_q[req_data.map_row] <= req_data.row_walls;
		end
	end

	// captured pose
	logic [6:0]  col_q;
	logic [15:0] px_q, py_q;
	logic [11:0] head_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q  <= req_data.column;
			px_q   <= req_data.pos_x;
			py_q   <= req_data.pos_y;
			head_q <= req_data.heading;
		end
	end

	// ray angle
	logic [18:0] prod_q;
	logic [11:0] ang_q;
	logic [42:0] recip_prod;

	assign recip_prod = 43'(prod_q) * 43'(grc_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (cmd.ang1) prod_q <= 19'(col_q) * 19'(fov_q);
		if (cmd.ang2) ang_q <= head_q - 12'(fov_q >> 1)
			+ recip_prod[grc_pkg::RECIP_SHIFT +: 12];
	end

	// sine and cosine lanes
	logic [14:0] t_q  [2];
	logic [14:0] t2_q [2];
	logic [14:0] p_q  [2];
	logic        neg_q [2];
	logic signed [15:0] ex_q, ey_q;

	logic [11:0] lane_a [2];
	logic [10:0] arg    [2];
	logic [14:0] t_in   [2];
	logic [29:0] sq_in  [2];
	logic [29:0] tp_mul [2];
	logic [29:0] rp_mul [2];
	logic [15:0] rmag   [2];
	logic [14:0] coef;

	always_comb begin
		lane_a[0] = ang_q;
		lane_a[1] = ang_q + 12'd1024;
		for (int l = 0; l < 2; l++) begin
			arg[l]    = lane_a[l][10] ? (11'd1024 - {1'b0, lane_a[l][9:0]})
			                          : {1'b0, lane_a[l][9:0]};
			t_in[l]   = {arg[l], 4'b0};
			sq_in[l]  = 30'(t_in[l]) * 30'(t_in[l]);
			tp_mul[l] = 30'(t2_q[l]) * 30'(p_q[l]);
			rp_mul[l] = 30'(t_q[l]) * 30'(p_q[l]);
			rmag[l]   = rp_mul[l][29:14];
		end
		case (cmd.phase)
			3'd1:    coef = grc_pkg::POLY_C1;
			3'd2:    coef = grc_pkg::POLY_C2;
			default: coef = grc_pkg::POLY_C3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.trig) begin
			for (int l = 0; l < 2; l++) begin
				if (cmd.phase == 3'd0) begin
					t_q[l]   <= t_in[l];
					t2_q[l]  <= sq_in[l][28:14];
					p_q[l]   <= grc_pkg::POLY_C0;
					neg_q[l] <= lane_a[l][11];
				end else if (cmd.phase != 3'(grc_pkg::TRIG_PHASES - 1)) begin
					p_q[l] <= coef - 15'(tp_mul[l][29:14]);
				end
			end
			if (cmd.phase == 3'(grc_pkg::TRIG_PHASES - 1)) begin
				ex_q <= neg_q[0] ? -$signed(rmag[0]) : $signed(rmag[0]);
				ey_q <= neg_q[1] ? -$signed(rmag[1]) : $signed(rmag[1]);
			end
		end
	end

	// march setup and stepping
	logic [12:0] step_e_q;
	logic signed [29:0] exs_q, eys_q;
	logic [21:0] en_q;
	logic signed [34:0] vx_q, vy_q;
	logic [16:0] dist_q;
	logic [3:0]  cx_q, cy_q;

	logic [12:0] step_eff;
	logic signed [31:0] sqx, sqy;
	logic [31:0] esum;
	logic signed [34:0] base_x, base_y, clamp_x, clamp_y;
	logic [17:0] dsum;
	logic out_map, wall, deep;

	always_comb begin
		step_eff = (step_q == '0) ? 13'd1 : step_q;
		sqx      = ex_q * ex_q;
		sqy      = ey_q * ey_q;
		esum     = 32'(sqx) + 32'(sqy);
		base_x   = $signed({5'b0, px_q, 14'b0});
		base_y   = $signed({5'b0, py_q, 14'b0});
		clamp_x  = base_x + (35'(ex_q) <<< 17) - 35'(ex_q);
		clamp_y  = base_y + (35'(ey_q) <<< 17) - 35'(ey_q);
		dsum     = {1'b0, dist_q} + 18'(step_e_q);
		out_map  = vx_q[34] || vy_q[34]
		        || (int'(vx_q[33:26]) >= grc_pkg::MAP_SIZE)
		        || (int'(vy_q[33:26]) >= grc_pkg::MAP_SIZE);
		wall     = !out_map && map_q[vy_q[29:26]][vx_q[29:26]];
		deep     = dist_q >= depth_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			step_e_q <= step_eff;
			exs_q    <= ex_q * $signed({1'b0, step_eff});
			eys_q    <= ey_q * $signed({1'b0, step_eff});
			en_q     <= esum[29:8];
			vx_q     <= base_x;
			vy_q     <= base_y;
			dist_q   <= '0;
		end else if (cmd.mfirst || (cmd.march && !(out_map || wall || deep))) begin
			if (dsum[17]) begin
				dist_q <= grc_pkg::DIST_MAX;
				vx_q   <= clamp_x;
				vy_q   <= clamp_y;
			end else begin
				dist_q <= dsum[16:0];
				vx_q   <= vx_q + 35'(exs_q);
				vy_q   <= vy_q + 35'(eys_q);
			end
		end else if (cmd.march && out_map) begin
			dist_q <= depth_q;
		end
		if (cmd.march && wall) begin
			cx_q <= vx_q[29:26];
			cy_q <= vy_q[29:26];
		end
	end

	// corner test pipeline, one corner enters per cycle
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [1:0]         k_s1, k_s2, k_s3, k_s4;
	logic signed [17:0] cvx_s1, cvy_s1;
	logic signed [33:0] pdx_s2, pdy_s2;
	logic [33:0]        nx_s2, ny_s2;
	logic signed [34:0] dot_s3;
	logic [34:0]        norm_s3, norm_s4;
	logic               pos_s4;
	logic [53:0]        dd_s4;
	logic [39:0]        ll_s4;
	logic [38:0]        lh_s4;
	logic [3:0]         close_q;
	logic [1:0]         far_q;
	logic [34:0]        fnorm_q;

	logic signed [35:0] sqcx, sqcy;
	logic [26:0]        dmag;
	logic [57:0]        lim, thr;
	logic               close;
	logic               edge_hit;

	always_comb begin
		sqcx     = cvx_s1 * cvx_s1;
		sqcy     = cvy_s1 * cvy_s1;
		dmag     = dot_s3[30:4];
		lim      = {1'b0, lh_s4, 18'b0} + 58'(ll_s4);
		thr      = lim - (lim >> 13);
		close    = pos_s4 && (58'(dd_s4) > thr);
		edge_hit = |(close_q & ~(4'b0001 << far_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.edge_feed;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		k_s1   <= cmd.edge_idx;
		k_s2   <= k_s1;
		k_s3   <= k_s2;
		k_s4   <= k_s3;
		cvx_s1 <= $signed({1'b0, 5'({1'b0, cx_q}) + 5'(cmd.edge_idx[1]), 12'b0})
		        - $signed({2'b0, px_q});
		cvy_s1 <= $signed({1'b0, 5'({1'b0, cy_q}) + 5'(cmd.edge_idx[0]), 12'b0})
		        - $signed({2'b0, py_q});
		pdx_s2 <= ex_q * cvx_s1;
		pdy_s2 <= ey_q * cvy_s1;
		nx_s2  <= sqcx[33:0];
		ny_s2  <= sqcy[33:0];
		dot_s3  <= 35'(pdx_s2) + 35'(pdy_s2);
		norm_s3 <= 35'(nx_s2) + 35'(ny_s2);
		pos_s4  <= dot_s3 > 35'sd0;
		dd_s4   <= 54'(dmag) * 54'(dmag);
		ll_s4   <= 40'(en_q) * 40'(norm_s3[17:0]);
		lh_s4   <= 39'(en_q) * 39'(norm_s3[34:18]);
		norm_s4 <= norm_s3;
		if (cmd.setup) begin
			close_q <= '0;
			far_q   <= '0;
			fnorm_q <= '0;
		end else if (v_s4) begin
			close_q[k_s4] <= close;
			if (norm_s4 >= fnorm_q) begin
				far_q   <= k_s4;
				fnorm_q <= norm_s4;
			end
		end
	end

	// projected height divider, one quotient bit per cycle
	logic [grc_pkg::DIV_W-1:0] quo_q;
	logic [16:0] rem_q;
	logic [17:0] rsh;
	logic [18:0] diff;

	always_comb begin
		rsh  = {rem_q, quo_q[grc_pkg::DIV_W-1]};
		diff = {1'b0, rsh} - {2'b0, dist_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q <= grc_pkg::DIV_NUM;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= diff[18] ? rsh[16:0] : diff[16:0];
			quo_q <= {quo_q[grc_pkg::DIV_W-2:0], ~diff[18]};
		end
	end

	// row limits and wall shade
	logic signed [19:0] ceil_q, floor_q;
	logic [3:0]         gw_q;
	logic signed [31:0] hval, hneg, cfull;
	logic [18:0]        d4, d3, d2;
	logic [3:0]         gw;

	always_comb begin
		hval  = 32'(grc_pkg::SCREEN_HEIGHT * 2048) - $signed({2'b0, quo_q});
		hneg  = -hval;
		cfull = hval[31] ? -(hneg >>> 12) : (hval >>> 12);
		d4    = {dist_q, 2'b0};
		d3    = {2'b0, dist_q} + {1'b0, dist_q, 1'b0};
		d2    = {1'b0, dist_q, 1'b0};
		if (d4 <= 19'(depth_q)) gw = grc_pkg::GL_FULL;
		else if (d3 < 19'(depth_q)) gw = grc_pkg::GL_DARK;
		else if (d2 < 19'(depth_q)) gw = grc_pkg::GL_MEDIUM;
		else if (dist_q < depth_q) gw = grc_pkg::GL_LIGHT;
		else gw = grc_pkg::GL_BLANK;
		if (edge_hit) gw = grc_pkg::GL_BLANK;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			ceil_q  <= (dist_q == '0) ? -20'sd40 + 20'sd40 - 20'(grc_pkg::SCREEN_HEIGHT)
			                          : cfull[19:0];
			floor_q <= (dist_q == '0) ? 20'(2 * grc_pkg::SCREEN_HEIGHT)
			                          : 20'(grc_pkg::SCREEN_HEIGHT) - cfull[19:0];
			gw_q    <= gw;
		end
	end

	// output register
	logic signed [19:0] row_s;
	logic [3:0]         g;

	always_comb begin
		row_s = $signed({14'b0, cmd.row});
		if (row_s <= ceil_q) g = grc_pkg::GL_BLANK;
		else if (row_s <= floor_q) g = gw_q;
		else g = grc_pkg::floor_glyph(cmd.row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_data.screen_row    <= cmd.row;
			rsp_data.glyph         <= g;
			rsp_data.wall_distance <= dist_q;
			rsp_data.tile_edge     <= edge_hit;
			rsp_data.last_row      <= (cmd.row == 6'(grc_pkg::SCREEN_HEIGHT - 1));
		end
	end

	assign sts.depth_zero = (depth_q == '0);
	assign sts.m_end      = out_map || wall || deep;
	assign sts.m_wall     = wall;
	assign sts.out_free   = !rsp_valid || rsp_ready;

endmodule

@@ hw/rtl/grid_raycast_column_core.sv @@
`timescale 1ns / 1ps
// top level of the grid ray-cast column core
//
// req carries one command per transfer: a map row write loads one row of the
// 16x16 wall bitmap, a cast renders one screen column from the player pose.
// rsp returns the 40 glyphs of a cast, top row first, last_row set on the
// final one. a map write is stored while idle and gives no transfer on rsp.
// a cast runs the angle, the sine/cosine polynomial, the setup, the ray
// march (up to view_depth/step_length steps, rounded up), the corner test
// when a wall is hit, the height divider (one quotient bit a cycle), the
// row limits, and then 40 rows leave through the output register at one
// per cycle while rsp does not stall.
// req is ready only between casts; the last row of a column may still sit
// in the output register while the next command is taken.
// if rsp stalls, the row counter waits and the held row stays on rsp.
// reset clears the wall map and the state machine and loads the default
// view depth, field of view and step length. the cfg port writes one
// register per cycle and is meant for use while the core is idle.
module grid_raycast_column_core (
	input  logic                              clk,
	input  logic                              arst_n,
	grc_stream_if.sink                        req,
	grc_stream_if.source                      rsp,
	input  logic                              cfg_we,
	input  logic [grc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [grc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	grc_pkg::cmd_t cmd;
	grc_pkg::sts_t sts;
	grc_pkg::req_t req_data;
	grc_pkg::rsp_t rsp_data;
	logic          req_ready;
	logic          rsp_valid;

	assign req_data = req.payload;

	// sequencer
	grc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req_data.opcode),
		.req_ready  (req_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// map, trig, march, corner test, divider and output register
	grc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = rsp_data;

endmodule

@@ hw/rtl/grc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the ray-cast column core and their binding
module grc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          req_opcode,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input grc_pkg::rsp_t rsp_payload
);

	// a held row does not change under stall
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("rsp payload changed while stalled");

	// last_row flags exactly the bottom row
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_payload.last_row
			== (rsp_payload.screen_row == 6'(grc_pkg::SCREEN_HEIGHT - 1))))
		else $error("last_row does not match screen_row");

	// a cast transfer makes the core busy
	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == grc_pkg::OP_CAST |=> !req_ready)
		else $error("req ready right after a cast");

	// while a row other than the last is shown, the column is still in progress
	a_col_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_payload.last_row |-> !req_ready)
		else $error("req ready in the middle of a column");

endmodule

bind grid_raycast_column_core grc_checker u_grc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_opcode  (req.payload.opcode),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
